FILE: src/ftce_pkg.sv
// Package for the clock-replacement frame table: codes, payload structs and the FSM state type.
// Depends on nothing. The RAM module and the top level both use it.
package ftce_pkg;

  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_ACCESS = 2'd2,
    CMD_EVICT  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    ACT_DROP  = 2'd0,
    ACT_WBACK = 2'd1,
    ACT_SWAP  = 2'd2
  } action_code_t;

  localparam logic [1:0] KIND_FILE = 2'd0;
  localparam logic [1:0] KIND_SWAP = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [19:0] frame_number;
    logic [19:0] page_tag;
    logic [1:0]  backing_kind;
    logic        is_write;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        victim_valid;
    logic [19:0] victim_frame;
    logic [19:0] victim_page;
    logic [1:0]  victim_action;
    logic [1:0]  victim_new_kind;
    logic [6:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [19:0] frame;
    logic [19:0] page;
    logic [1:0]  kind;
    logic        accessed;
    logic        dirty;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_FIN
  } state_t;

endpackage

FILE: src/ftce_ram.sv
// Single-port-write, single-port-read entry RAM with registered read data.
// Depends on ftce_pkg for the entry type.
module ftce_ram
  import ftce_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/frame_table_clock_eviction.sv
// Top level of the clock (second chance) frame table.
// An insert into a non-full table passes through S_APPEND and S_FIN before its result is
// registered; a search reads and checks each entry visited (S_FIND_RD, S_FIND_CHK), the clock
// scan each entry passed (S_SCAN_RD, S_SCAN_CHK), and compaction each entry moved after the
// victim (S_SHIFT_RD, S_SHIFT_WR). One transaction at a time: cmd_stall is high outside
// S_IDLE. Reset (rst, sync) empties the table, hand to slot 0.
module frame_table_clock_eviction
  import ftce_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  in_t  cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output out_t rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(CAPACITY);

  state_t state, state_next;

  // Held transaction and working registers.
  in_t              item;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] hand;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] vidx;
  out_t             res;

  // RAM controls.
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  entry_t           rdata;

  logic             accept;
  logic [CNT_W-1:0] ptr_inc;
  logic [CNT_W-1:0] hand_inc;
  logic             ptr_more;
  logic [IDX_W-1:0] hand_adj;
  logic [CNT_W-1:0] count_dec;
  logic [1:0]       ins_kind;
  logic [1:0]       v_action;
  logic [1:0]       v_kind;
  logic             out_free;
  in_t              item_next;
  out_t             res_start;
  out_t             rsp_next;

  ftce_ram #(.CAPACITY(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign ptr_inc   = CNT_W'(ptr) + CNT_W'(1);
  assign hand_inc  = CNT_W'(hand) + CNT_W'(1);
  assign ptr_more  = (ptr_inc < count);
  assign count_dec = count - CNT_W'(1);
  assign ins_kind  = (cmd.backing_kind == 2'd3) ? KIND_LOAD : cmd.backing_kind;

  // Captured command with its kind clamped, and the result it starts from.
  always_comb begin
    item_next              = cmd;
    item_next.backing_kind = ins_kind;
    res_start              = '0;
    if (count == '0 && cmd.command == CMD_EVICT) begin
      res_start.status = ST_EMPTY;
    end else if (count == '0 && cmd.command != CMD_INSERT) begin
      res_start.status = ST_NOT_FOUND;
    end
  end

  // Result with the entry count after this transaction.
  always_comb begin
    rsp_next             = res;
    rsp_next.entry_count = 7'(count);
  end

  // Hand after a removal at vidx: step back if the victim sat below it, wrap past the end.
  always_comb begin
    hand_adj = (vidx < hand) ? hand - IDX_W'(1) : hand;
    if (CNT_W'(hand_adj) >= count_dec) begin
      hand_adj = '0;
    end
  end

  // Fate of the victim from its kind and dirty mark.
  always_comb begin
    v_action = ACT_DROP;
    v_kind   = rdata.kind;
    case (rdata.kind)
      KIND_FILE: if (rdata.dirty) v_action = ACT_WBACK;
      KIND_SWAP: v_action = ACT_SWAP;
      KIND_LOAD: begin
        if (rdata.dirty) begin
          v_action = ACT_SWAP;
          v_kind   = KIND_SWAP;
        end
      end
      default: v_action = ACT_DROP;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.command)
            CMD_INSERT: state_next = (count >= FULL) ? S_SCAN_RD : S_APPEND;
            CMD_FREE, CMD_ACCESS: state_next = (count == '0) ? S_FIN : S_FIND_RD;
            default: state_next = (count == '0) ? S_FIN : S_SCAN_RD;
          endcase
        end
      end
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: state_next = rdata.accessed ? S_SCAN_RD : S_SHIFT_RD;
      S_FIND_RD:  state_next = S_FIND_CHK;
      S_FIND_CHK: begin
        if (rdata.frame == item.frame_number) begin
          state_next = (item.command == CMD_FREE) ? S_SHIFT_RD : S_FIN;
        end else begin
          state_next = ptr_more ? S_FIND_RD : S_FIN;
        end
      end
      S_SHIFT_RD: begin
        if (ptr_more) begin
          state_next = S_SHIFT_WR;
        end else begin
          state_next = (item.command == CMD_INSERT) ? S_APPEND : S_FIN;
        end
      end
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_APPEND:   state_next = S_FIN;
      S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM port controls.
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = rdata;
    raddr = ptr;
    case (state)
      S_SCAN_RD: raddr = hand;
      S_SCAN_CHK: begin
        // Clear the second-chance mark as the hand passes.
        if (rdata.accessed) begin
          we             = 1'b1;
          waddr          = hand;
          wdata.accessed = 1'b0;
        end
      end
      S_FIND_CHK: begin
        if (rdata.frame == item.frame_number && item.command == CMD_ACCESS) begin
          we             = 1'b1;
          wdata.accessed = 1'b1;
          wdata.dirty    = rdata.dirty | item.is_write;
        end
      end
      S_SHIFT_RD: raddr = ptr_inc[IDX_W-1:0];
      S_SHIFT_WR: we = 1'b1;
      S_APPEND: begin
        we             = 1'b1;
        waddr          = count[IDX_W-1:0];
        wdata.frame    = item.frame_number;
        wdata.page     = item.page_tag;
        wdata.kind     = item.backing_kind;
        wdata.accessed = 1'b0;
        wdata.dirty    = 1'b0;
      end
      default: we = 1'b0;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      hand  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= item_next;
            res  <= res_start;
            ptr  <= '0;
            if (CNT_W'(hand) >= count) begin
              hand <= '0;
            end
          end
        end
        S_SCAN_CHK: begin
          if (rdata.accessed) begin
            hand <= (hand_inc >= count) ? '0 : hand_inc[IDX_W-1:0];
          end else begin
            // Victim found: report it and compact from its slot.
            res.victim_valid    <= 1'b1;
            res.victim_frame    <= rdata.frame;
            res.victim_page     <= rdata.page;
            res.victim_action   <= v_action;
            res.victim_new_kind <= v_kind;
            vidx                <= hand;
            ptr                 <= hand;
          end
        end
        S_FIND_CHK: begin
          if (rdata.frame == item.frame_number) begin
            vidx <= ptr;
          end else if (ptr_more) begin
            ptr <= ptr_inc[IDX_W-1:0];
          end else begin
            res.status <= ST_NOT_FOUND;
          end
        end
        S_SHIFT_RD: begin
          if (!ptr_more) begin
            count <= count_dec;
            hand  <= hand_adj;
          end
        end
        S_SHIFT_WR: ptr <= ptr_inc[IDX_W-1:0];
        S_APPEND:   count <= count + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
